[rtl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants, codes and controller/datapath link types for the
// cooperative task scheduler.
// ----------------------------------------------------------------------------
package cts_pkg;

    // table geometry
    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // field widths
    localparam int HANDLE_W  = 8;
    localparam int TIME_W    = 32;
    localparam int TICK_W    = 16;
    localparam int SLOT_W    = 3;
    localparam int PEND_W    = 8;
    localparam int DIV_CNT_W = $clog2(TIME_W + 1);

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10);
    localparam logic [PEND_W-1:0] PEND_MAX   = '1;

    // request codes
    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_TICK     = 2'd1,
        REQ_DISPATCH = 2'd2,
        REQ_REMOVE   = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_NONE_DUE  = 2'd3
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DLY_START,
        S_DLY_WAIT,
        S_PER_START,
        S_PER_WAIT,
        S_ADD_WR,
        S_REMOVE,
        S_RESP,
        S_DISP_STEP,
        S_DISP_END
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic walk_clear;
        logic div_start;
        logic div_sel;
        logic dly_latch;
        logic add_write;
        logic tick_apply;
        logic remove_apply;
        logic resp_push;
        logic disp_step;
        logic disp_end;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        req_t req;
        logic full;
        logic div_done;
        logic out_free;
        logic walk_end;
        logic entry_due;
        logic hold_valid;
    } dp_status_t;

endpackage

[rtl/cts_if.sv]
// ----------------------------------------------------------------------------
// cts_if
// Valid/ready channels for scheduler requests and results.
// ----------------------------------------------------------------------------
interface cts_req_if;
    import cts_pkg::*;

    logic                valid;
    logic                ready;
    req_t                req_type;
    logic [HANDLE_W-1:0] task_handle;
    logic [TIME_W-1:0]   delay_ms;
    logic [TIME_W-1:0]   period_ms;
    logic [SLOT_W-1:0]   task_index;

    modport source (
        output valid, req_type, task_handle, delay_ms, period_ms, task_index,
        input  ready
    );

    modport sink (
        input  valid, req_type, task_handle, delay_ms, period_ms, task_index,
        output ready
    );
endinterface

interface cts_resp_if;
    import cts_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [HANDLE_W-1:0] due_handle;
    logic [SLOT_W-1:0]   slot;
    logic                last;

    modport source (
        output valid, status, due_handle, slot, last,
        input  ready
    );

    modport sink (
        input  valid, status, due_handle, slot, last,
        output ready
    );
endinterface

[rtl/cts_divider.sv]
// ----------------------------------------------------------------------------
// cts_divider
// Restoring divider, one quotient bit per cycle: millisecond value divided
// by the tick length (zero divisor treated as one).
// ----------------------------------------------------------------------------
module cts_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cts_pkg::TIME_W-1:0]  dividend,
    input  logic [cts_pkg::TICK_W-1:0]  divisor,
    output logic [cts_pkg::TIME_W-1:0]  quotient,
    output logic                        done
);
    import cts_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [TICK_W-1:0]    rem_reg, rem_next;
    logic [TICK_W-1:0]    dsr_reg, dsr_next;
    logic [TIME_W-1:0]    quo_reg, quo_next;
    logic [TICK_W:0]      shifted;
    logic [TICK_W:0]      trial;

    // trial subtraction of the divisor from the shifted remainder
    assign shifted = {rem_reg, quo_reg[TIME_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    // iteration step
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = dividend;
            dsr_next   = (divisor == '0) ? TICK_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[TICK_W])
            begin
                rem_next = trial[TICK_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[TICK_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_CNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[rtl/cts_datapath.sv]
// ----------------------------------------------------------------------------
// cts_datapath
// Task table, request holding registers, divider, dispatch walk registers
// and the result output register.
// ----------------------------------------------------------------------------
module cts_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cts_pkg::TICK_W-1:0]    cfg_wr_data,
    input  cts_pkg::req_t                 in_req_type,
    input  logic [cts_pkg::HANDLE_W-1:0]  in_task_handle,
    input  logic [cts_pkg::TIME_W-1:0]    in_delay_ms,
    input  logic [cts_pkg::TIME_W-1:0]    in_period_ms,
    input  logic [cts_pkg::SLOT_W-1:0]    in_task_index,
    input  cts_pkg::cmd_t                 cmd,
    output cts_pkg::dp_status_t           st,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cts_pkg::status_t              out_status,
    output logic [cts_pkg::HANDLE_W-1:0]  out_due_handle,
    output logic [cts_pkg::SLOT_W-1:0]    out_slot,
    output logic                          out_last
);
    import cts_pkg::*;

    // configuration
    logic [TICK_W-1:0]   tick_len_reg;

    // held request
    req_t                req_reg;
    logic [HANDLE_W-1:0] handle_in_reg;
    logic [TIME_W-1:0]   dly_ms_reg;
    logic [TIME_W-1:0]   per_ms_reg;
    logic [SLOT_W-1:0]   idx_in_reg;
    logic [TIME_W-1:0]   dly_q_reg;

    // task table
    logic [HANDLE_W-1:0] handle_reg [MAX_TASKS];
    logic [HANDLE_W-1:0] handle_next [MAX_TASKS];
    logic [TIME_W-1:0]   delay_reg [MAX_TASKS];
    logic [TIME_W-1:0]   delay_next [MAX_TASKS];
    logic [TIME_W-1:0]   period_reg [MAX_TASKS];
    logic [TIME_W-1:0]   period_next [MAX_TASKS];
    logic [PEND_W-1:0]   pend_reg [MAX_TASKS];
    logic [PEND_W-1:0]   pend_next [MAX_TASKS];
    logic [CNT_W-1:0]    occ_reg, occ_next;

    // dispatch walk
    logic [CNT_W-1:0]    walk_idx_reg, walk_idx_next;
    logic [SLOT_W-1:0]   orig_reg, orig_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [HANDLE_W-1:0] hold_handle_reg, hold_handle_next;
    logic [SLOT_W-1:0]   hold_slot_reg, hold_slot_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_last_reg, out_last_next;

    // divider link
    logic [TIME_W-1:0]   div_dividend;
    logic [TIME_W-1:0]   div_quotient;
    logic                div_done;

    // decoded conditions
    logic [IDX_W-1:0]    cur;
    logic                walk_end;
    logic                entry_due;
    logic                cur_one_shot;
    logic                idx_ok;
    logic                full;
    logic                out_free;
    logic                dec_en;
    logic                rm_en;
    logic [CNT_W-1:0]    rm_pos;
    logic                hold_push;

    // single-result fields
    status_t             resp_status;
    logic [HANDLE_W-1:0] resp_handle;
    logic [SLOT_W-1:0]   resp_slot;

    // divider shared by delay and period
    assign div_dividend = cmd.div_sel ? per_ms_reg : dly_ms_reg;

    cts_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (tick_len_reg),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // conditions seen by the controller
    assign cur          = walk_idx_reg[IDX_W-1:0];
    assign walk_end     = walk_idx_reg >= occ_reg;
    assign entry_due    = pend_reg[cur] != '0;
    assign cur_one_shot = period_reg[cur] == '0;
    assign idx_ok       = CNT_W'(idx_in_reg) < occ_reg;
    assign full         = occ_reg == CNT_W'(MAX_TASKS);
    assign out_free     = !out_valid_reg || out_ready;

    assign st.req        = req_reg;
    assign st.full       = full;
    assign st.div_done   = div_done;
    assign st.out_free   = out_free;
    assign st.walk_end   = walk_end;
    assign st.entry_due  = entry_due;
    assign st.hold_valid = hold_valid_reg;

    // dispatch and remove actions on the table
    assign dec_en    = cmd.disp_step && entry_due;
    assign hold_push = dec_en && hold_valid_reg;

    always_comb
    begin
        rm_en  = 1'b0;
        rm_pos = walk_idx_reg;
        if (cmd.remove_apply && idx_ok)
        begin
            rm_en  = 1'b1;
            rm_pos = CNT_W'(idx_in_reg);
        end
        else if (dec_en && cur_one_shot)
        begin
            rm_en = 1'b1;
        end
    end

    // table next state
    always_comb
    begin
        handle_next = handle_reg;
        delay_next  = delay_reg;
        period_next = period_reg;
        pend_next   = pend_reg;
        occ_next    = occ_reg;

        // add at the first free position
        if (cmd.add_write)
        begin
            for (int j = 0; j < MAX_TASKS; j++)
            begin
                if (CNT_W'(j) == occ_reg)
                begin
                    handle_next[j] = handle_in_reg;
                    delay_next[j]  = dly_q_reg;
                    period_next[j] = div_quotient;
                    pend_next[j]   = '0;
                end
            end
            occ_next = occ_reg + 1'b1;
        end

        // tick every occupied entry
        if (cmd.tick_apply)
        begin
            for (int j = 0; j < MAX_TASKS; j++)
            begin
                if (CNT_W'(j) < occ_reg)
                begin
                    if (delay_reg[j] != '0)
                    begin
                        delay_next[j] = delay_reg[j] - 1'b1;
                    end
                    else
                    begin
                        delay_next[j] = period_reg[j];
                        if (pend_reg[j] != PEND_MAX)
                        begin
                            pend_next[j] = pend_reg[j] + 1'b1;
                        end
                    end
                end
            end
        end

        // take one pending run off the dispatched entry
        if (dec_en)
        begin
            pend_next[cur] = pend_reg[cur] - 1'b1;
        end

        // removal shifts later entries down
        if (rm_en)
        begin
            for (int j = 0; j < MAX_TASKS; j++)
            begin
                if (CNT_W'(j) >= rm_pos)
                begin
                    if (j < MAX_TASKS - 1)
                    begin
                        handle_next[j] = handle_reg[j + 1];
                        delay_next[j]  = delay_reg[j + 1];
                        period_next[j] = period_reg[j + 1];
                        pend_next[j]   = pend_reg[j + 1];
                    end
                    else
                    begin
                        handle_next[j] = '0;
                        delay_next[j]  = '0;
                        period_next[j] = '0;
                        pend_next[j]   = '0;
                    end
                end
            end
            occ_next = occ_reg - 1'b1;
        end
    end

    // dispatch walk next state
    always_comb
    begin
        walk_idx_next    = walk_idx_reg;
        orig_next        = orig_reg;
        hold_valid_next  = hold_valid_reg;
        hold_handle_next = hold_handle_reg;
        hold_slot_next   = hold_slot_reg;
        if (cmd.walk_clear)
        begin
            walk_idx_next   = '0;
            orig_next       = '0;
            hold_valid_next = 1'b0;
        end
        else if (cmd.disp_step)
        begin
            if (entry_due)
            begin
                hold_valid_next  = 1'b1;
                hold_handle_next = handle_reg[cur];
                hold_slot_next   = orig_reg;
                if (!cur_one_shot)
                begin
                    walk_idx_next = walk_idx_reg + 1'b1;
                end
            end
            else
            begin
                walk_idx_next = walk_idx_reg + 1'b1;
            end
            orig_next = orig_reg + 1'b1;
        end
        else if (cmd.disp_end)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // single result for add, tick and remove
    always_comb
    begin
        resp_status = ST_OK;
        resp_handle = '0;
        resp_slot   = '0;
        unique case (req_reg) inside
            REQ_ADD:
            begin
                if (full)
                begin
                    resp_status = ST_FULL;
                end
                else
                begin
                    resp_handle = handle_in_reg;
                    resp_slot   = occ_reg[SLOT_W-1:0];
                end
            end
            REQ_TICK, REQ_DISPATCH:
            begin
                resp_status = ST_OK;
            end
            REQ_REMOVE:
            begin
                resp_slot = idx_in_reg;
                if (idx_ok)
                begin
                    resp_handle = handle_reg[idx_in_reg[IDX_W-1:0]];
                end
                else
                begin
                    resp_status = ST_BAD_INDEX;
                end
            end
        endcase
    end

    // output register loading
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.resp_push)
        begin
            out_valid_next  = 1'b1;
            out_status_next = resp_status;
            out_handle_next = resp_handle;
            out_slot_next   = resp_slot;
            out_last_next   = 1'b1;
        end
        else if (hold_push)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_handle_next = hold_handle_reg;
            out_slot_next   = hold_slot_reg;
            out_last_next   = 1'b0;
        end
        else if (cmd.disp_end)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            if (hold_valid_reg)
            begin
                out_status_next = ST_OK;
                out_handle_next = hold_handle_reg;
                out_slot_next   = hold_slot_reg;
            end
            else
            begin
                out_status_next = ST_NONE_DUE;
                out_handle_next = '0;
                out_slot_next   = '0;
            end
        end
    end

    // control and table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_len_reg   <= TICK_RESET;
            occ_reg        <= '0;
            walk_idx_reg   <= '0;
            orig_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int j = 0; j < MAX_TASKS; j++)
            begin
                handle_reg[j] <= '0;
                delay_reg[j]  <= '0;
                period_reg[j] <= '0;
                pend_reg[j]   <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tick_len_reg <= cfg_wr_data;
            end
            occ_reg        <= occ_next;
            walk_idx_reg   <= walk_idx_next;
            orig_reg       <= orig_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            handle_reg     <= handle_next;
            delay_reg      <= delay_next;
            period_reg     <= period_next;
            pend_reg       <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg       <= in_req_type;
            handle_in_reg <= in_task_handle;
            dly_ms_reg    <= in_delay_ms;
            per_ms_reg    <= in_period_ms;
            idx_in_reg    <= in_task_index;
        end
        if (cmd.dly_latch)
        begin
            dly_q_reg <= div_quotient;
        end
        hold_handle_reg <= hold_handle_next;
        hold_slot_reg   <= hold_slot_next;
        out_status_reg  <= out_status_next;
        out_handle_reg  <= out_handle_next;
        out_slot_reg    <= out_slot_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_due_handle = out_handle_reg;
    assign out_slot       = out_slot_reg;
    assign out_last       = out_last_reg;

`ifndef ASSERT_OFF
    // occupancy never exceeds the table
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(MAX_TASKS))
        else $error("occupancy beyond table size");

    // occupancy moves by at most one entry per cycle
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |->
            (occ_reg == $past(occ_reg) + 1'b1 || occ_reg == $past(occ_reg) - 1'b1))
        else $error("occupancy jumped");

    // a result is only loaded when the output register can take it
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.resp_push || hold_push || cmd.disp_end) |-> out_free)
        else $error("result loaded over a waiting item");

    // no add into a full table
    a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_write |-> !full)
        else $error("add written into a full table");

    // the held dispatch result is gone after the final one goes out
    a_hold_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.disp_end |=> !hold_valid_reg)
        else $error("held dispatch result left behind");
`endif

endmodule

[rtl/cts_ctrl.sv]
// ----------------------------------------------------------------------------
// cts_ctrl
// Request sequencer: decodes the held request and steps the datapath
// through division, table update, dispatch walk and result output.
// ----------------------------------------------------------------------------
module cts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cts_pkg::dp_status_t  st,
    output cts_pkg::cmd_t        cmd
);
    import cts_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (st.req)
                    REQ_ADD:      state_next = st.full ? S_RESP : S_DLY_START;
                    REQ_TICK:     state_next = S_RESP;
                    REQ_DISPATCH: state_next = S_DISP_STEP;
                    REQ_REMOVE:   state_next = S_REMOVE;
                endcase
            end
            S_DLY_START:
            begin
                state_next = S_DLY_WAIT;
            end
            S_DLY_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_PER_START;
                end
            end
            S_PER_START:
            begin
                state_next = S_PER_WAIT;
            end
            S_PER_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_ADD_WR;
                end
            end
            S_ADD_WR, S_REMOVE, S_RESP, S_DISP_END:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DISP_STEP:
            begin
                if (st.walk_end)
                begin
                    state_next = S_DISP_END;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                cmd.walk_clear = 1'b1;
                cmd.tick_apply = (st.req == REQ_TICK);
            end
            S_DLY_START:
            begin
                cmd.div_start = 1'b1;
            end
            S_DLY_WAIT:
            begin
                cmd.dly_latch = st.div_done;
            end
            S_PER_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
            end
            S_PER_WAIT:
            begin
                cmd.div_sel = 1'b1;
            end
            S_ADD_WR:
            begin
                cmd.add_write = st.out_free;
                cmd.resp_push = st.out_free;
            end
            S_REMOVE:
            begin
                cmd.remove_apply = st.out_free;
                cmd.resp_push    = st.out_free;
            end
            S_RESP:
            begin
                cmd.resp_push = st.out_free;
            end
            S_DISP_STEP:
            begin
                // a due entry pushes the held result out first
                cmd.disp_step = !st.walk_end &&
                                (!(st.entry_due && st.hold_valid) || st.out_free);
            end
            S_DISP_END:
            begin
                cmd.disp_end = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/cooperative_task_scheduler.sv]
// ----------------------------------------------------------------------------
// cooperative_task_scheduler
// Table of up to eight timed tasks, kept packed from position 0. Add divides
// the delay and period by tick_length (zero counts as one) with a bit-serial
// divider, the delay first and then the period; an add to a full table skips
// both divisions and answers with a full status. Tick updates all occupied
// entries at once. Dispatch gives one item per due task with last set on the
// final one, or a single none-due item with last set when no task is due.
// Every request is handled to its end before the next is accepted; a waiting
// result on the output stalls only the step that must load the next one. The
// table is cleared directly by reset, with no clearing pass. The user must
// write tick_length only while no request is in progress; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cts_pkg::TICK_W-1:0]  cfg_wr_data,
    cts_req_if.sink                     req,
    cts_resp_if.source                  resp
);
    import cts_pkg::*;

    cmd_t       cmd;
    dp_status_t st;
    logic       in_ready;

    assign req.ready = in_ready;

    // request sequencer
    cts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // table, divider and result register
    cts_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_req_type    (req.req_type),
        .in_task_handle (req.task_handle),
        .in_delay_ms    (req.delay_ms),
        .in_period_ms   (req.period_ms),
        .in_task_index  (req.task_index),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (resp.valid),
        .out_ready      (resp.ready),
        .out_status     (resp.status),
        .out_due_handle (resp.due_handle),
        .out_slot       (resp.slot),
        .out_last       (resp.last)
    );

endmodule
